@@ rtl/rtlk_pkg.sv @@
// Shared types and constants for the route table lookup block.
// No dependencies; imported by rtlk_cmp and route_table_lookup.
`default_nettype none

package rtlk_pkg;

  // metric handling
  localparam logic [9:0]  METRIC_CAP   = 10'd999;
  localparam logic [9:0]  METRIC_START = 10'd1000;
  localparam logic [31:0] GW_DIRECT    = 32'h0000_0000;

  // request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // result codes
  typedef enum logic [1:0] {
    OUT_NONE   = 2'd0,
    OUT_LOCAL  = 2'd1,
    OUT_REMOTE = 2'd2,
    OUT_WRITE  = 2'd3
  } outcome_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // one stored route entry (valid bit lives in flops)
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [9:0]  metric;
    logic [3:0]  port;
  } route_entry_t;

  // comparator flags back to the sequencer
  typedef struct packed {
    logic hit;
    logic local_hit;
    logic better;
  } cmp_res_t;

endpackage

`default_nettype wire

@@ rtl/rtlk_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rtlk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rtlk_cmp.sv @@
// Shared masked-match and metric comparator, used once per table entry.
// Depends on rtlk_pkg.
`default_nettype none

module rtlk_cmp (
  input  wire logic [31:0]          addr,
  input  wire rtlk_pkg::route_entry_t entry,
  input  wire logic                 entry_valid,
  input  wire logic [9:0]           best_metric,
  output rtlk_pkg::cmp_res_t        res
);

  import rtlk_pkg::*;

  logic match;
  logic direct;

  // address and destination agree under the mask
  assign match  = entry_valid && ((addr & entry.mask) == (entry.dest & entry.mask));
  assign direct = (entry.gateway == GW_DIRECT);

  // classify the entry
  always_comb begin
    res.hit       = match;
    res.local_hit = match && direct;
    res.better    = match && !direct && (entry.metric < best_metric);
  end

endmodule

`default_nettype wire

@@ rtl/route_table_lookup.sv @@
// Route table lookup block: entry storage, walk sequencer and result register.
// Depends on rtlk_pkg, rtlk_ram and rtlk_cmp.
//
// Input channel (in_*): one word is either a table write (req_type 0) or a
// lookup of in_lookup_addr (req_type 1). A word is taken when in_valid is
// high and in_stall is low; in_stall is high while a word is being worked on.
// Output channel (out_*): one result word per input word, held in an output
// register until taken (out_valid high, out_stall low).
// An accepted write passes through the result register into the output
// register. A lookup walks the table one entry per cycle through the RAM read
// port and one shared comparator; a directly attached route ends the walk
// early. The next word is accepted once the previous result has moved into
// the output register and the sequencer is idle again, so the block works on
// one word at a time.
// Reset clears all entry valid bits (the table reads as empty) and the
// handshake state; entry contents are kept until rewritten.
// When the receiver stalls, the result stays in the output register and a
// finished result behind it waits, holding in_stall high.
`default_nettype none

module route_table_lookup #(
  parameter int TABLE_DEPTH = 16,
  parameter int PORT_COUNT  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic        in_entry_valid,
  input  wire logic [31:0] in_entry_dest,
  input  wire logic [31:0] in_entry_mask,
  input  wire logic [31:0] in_entry_gateway,
  input  wire logic [15:0] in_entry_metric,
  input  wire logic [3:0]  in_entry_port,
  input  wire logic [31:0] in_lookup_addr,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_outcome,
  output logic [3:0]       out_index,
  output logic [3:0]       out_port,
  output logic [31:0]      out_gateway,
  output logic [9:0]       out_metric
);

  import rtlk_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(route_entry_t);

  state_t state_r, state_nxt;

  logic              accept_in;
  logic              write_go;
  logic              look_go;
  logic              out_free;
  logic              issue_more;
  logic              ram_re;
  logic              walk_local;
  logic              walk_scan_end;

  logic [31:0]       addr_r;
  logic [CW-1:0]     issue_cnt_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_idx_r;
  logic              valid_r [TABLE_DEPTH];

  logic              have_r;
  logic [9:0]        best_metric_r;
  logic [AW-1:0]     best_idx_r;
  logic [3:0]        best_port_r;
  logic [31:0]       best_gw_r;

  outcome_t          res_outcome_r;
  logic [3:0]        res_index_r;
  logic [3:0]        res_port_r;
  logic [31:0]       res_gw_r;
  logic [9:0]        res_metric_r;

  logic              out_valid_r;
  outcome_t          out_outcome_r;
  logic [3:0]        out_index_r;
  logic [3:0]        out_port_r;
  logic [31:0]       out_gw_r;
  logic [9:0]        out_metric_r;

  logic [8:0]        wr_idx9;
  logic [8:0]        rd_idx9;
  logic [8:0]        best_idx9;
  logic              wr_in_range;
  logic              port_ok;
  logic [AW-1:0]     wr_addr;
  logic              ram_we;
  route_entry_t      wr_entry;
  logic [EW-1:0]     rd_word;
  route_entry_t      rd_entry;
  logic              rd_entry_valid;
  cmp_res_t          cmp_res;

  // handshake decode
  assign accept_in = in_valid && !in_stall;
  assign write_go  = accept_in && (in_req_type == REQ_WRITE);
  assign look_go   = accept_in && (in_req_type == REQ_LOOKUP);
  assign out_free  = !out_valid_r || !out_stall;

  // write address and entry build
  assign wr_idx9     = 9'(in_entry_index);
  assign wr_in_range = wr_idx9 < 9'(TABLE_DEPTH);
  assign port_ok     = 9'(in_entry_port) < 9'(PORT_COUNT);
  assign wr_addr     = wr_idx9[AW-1:0];
  assign ram_we      = write_go && wr_in_range;

  always_comb begin
    wr_entry.dest    = in_entry_dest;
    wr_entry.mask    = in_entry_mask;
    wr_entry.gateway = in_entry_gateway;
    wr_entry.metric  = (in_entry_metric > 16'(METRIC_CAP)) ? METRIC_CAP
                                                           : in_entry_metric[9:0];
    wr_entry.port    = in_entry_port;
  end

  // entry storage
  rtlk_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (issue_cnt_r[AW-1:0]),
    .rdata (rd_word)
  );

  assign rd_entry       = route_entry_t'(rd_word);
  assign rd_entry_valid = valid_r[rd_idx_r];

  // shared comparator
  rtlk_cmp u_cmp (
    .addr        (addr_r),
    .entry       (rd_entry),
    .entry_valid (rd_entry_valid),
    .best_metric (best_metric_r),
    .res         (cmp_res)
  );

  // walk status
  assign issue_more    = issue_cnt_r < CW'(TABLE_DEPTH);
  assign walk_local    = (state_r == ST_WALK) && rd_vld_r && cmp_res.local_hit;
  assign walk_scan_end = (state_r == ST_WALK) && !issue_more && !rd_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (write_go) begin
          state_nxt = ST_FINISH;
        end else if (look_go) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_local || walk_scan_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    ram_re   = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_WALK:   ram_re   = issue_more && !walk_local;
      ST_FINISH: in_stall = 1'b1;
      default:   in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (ram_we) begin
      valid_r[wr_addr] <= in_entry_valid && port_ok;
    end
  end

  // walk counter and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (look_go) begin
        issue_cnt_r <= '0;
      end else if (ram_re) begin
        issue_cnt_r <= issue_cnt_r + CW'(1);
      end
      rd_vld_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_idx_r <= issue_cnt_r[AW-1:0];
    end
    if (look_go) begin
      addr_r <= in_lookup_addr;
    end
  end

  // best remote candidate so far
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r        <= 1'b0;
      best_metric_r <= METRIC_START;
    end else if (look_go) begin
      have_r        <= 1'b0;
      best_metric_r <= METRIC_START;
    end else if ((state_r == ST_WALK) && rd_vld_r && cmp_res.better) begin
      have_r        <= 1'b1;
      best_metric_r <= rd_entry.metric;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_WALK) && rd_vld_r && cmp_res.better) begin
      best_idx_r  <= rd_idx_r;
      best_port_r <= rd_entry.port;
      best_gw_r   <= rd_entry.gateway;
    end
  end

  assign rd_idx9   = 9'(rd_idx_r);
  assign best_idx9 = 9'(best_idx_r);

  // result capture
  always_ff @(posedge clk) begin
    if (write_go) begin
      res_outcome_r <= OUT_WRITE;
      res_index_r   <= in_entry_index;
      res_port_r    <= '0;
      res_gw_r      <= '0;
      res_metric_r  <= '0;
    end else if (walk_local) begin
      res_outcome_r <= OUT_LOCAL;
      res_index_r   <= rd_idx9[3:0];
      res_port_r    <= rd_entry.port;
      res_gw_r      <= '0;
      res_metric_r  <= rd_entry.metric;
    end else if (walk_scan_end) begin
      if (have_r) begin
        res_outcome_r <= OUT_REMOTE;
        res_index_r   <= best_idx9[3:0];
        res_port_r    <= best_port_r;
        res_gw_r      <= best_gw_r;
        res_metric_r  <= best_metric_r;
      end else begin
        res_outcome_r <= OUT_NONE;
        res_index_r   <= '0;
        res_port_r    <= '0;
        res_gw_r      <= '0;
        res_metric_r  <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FINISH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FINISH) && out_free) begin
      out_outcome_r <= res_outcome_r;
      out_index_r   <= res_index_r;
      out_port_r    <= res_port_r;
      out_gw_r      <= res_gw_r;
      out_metric_r  <= res_metric_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_index   = out_index_r;
  assign out_port    = out_port_r;
  assign out_gateway = out_gw_r;
  assign out_metric  = out_metric_r;

endmodule

`default_nettype wire
